// ----- hw/rtl/trs_pkg.sv -----
// Shared widths, constants and payload types of the TRS model matrix pipeline.
package trs_pkg;

  localparam int PosW   = 32;
  localparam int QuatW  = 16;
  localparam int ScaleW = 16;
  localparam int EntryW = 24;
  localparam int ProdW  = 2 * QuatW;
  localparam int RotW   = ProdW + 2;
  localparam int MulW   = RotW + ScaleW;
  localparam int Shift  = 22;
  localparam int QW     = MulW - Shift;
  localparam int NumEnt = 9;

  localparam logic signed [RotW-1:0] ONE_Q28    = RotW'(64'sd268435456);
  localparam logic signed [MulW-1:0] ROUND_BIAS = MulW'(64'sd2097152);

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [ScaleW-1:0] x;
    logic signed [ScaleW-1:0] y;
    logic signed [ScaleW-1:0] z;
  } scale_t;

  // fields that ride along with each word down the pipe
  typedef struct packed {
    pos_t   pos;
    scale_t scale;
  } side_t;

  typedef struct packed {
    logic signed [QuatW-1:0] w;
    logic signed [QuatW-1:0] x;
    logic signed [QuatW-1:0] y;
    logic signed [QuatW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [ProdW-1:0] xx;
    logic signed [ProdW-1:0] yy;
    logic signed [ProdW-1:0] zz;
    logic signed [ProdW-1:0] xy;
    logic signed [ProdW-1:0] xz;
    logic signed [ProdW-1:0] yz;
    logic signed [ProdW-1:0] wx;
    logic signed [ProdW-1:0] wy;
    logic signed [ProdW-1:0] wz;
  } prod_t;

  // round half up, drop Shift fraction bits, clamp to the entry range
  function automatic logic signed [EntryW-1:0] round_sat(input logic signed [MulW-1:0] p);
    logic signed [MulW-1:0] s;
    logic signed [QW-1:0]   q;
    logic                   ovf;
    s   = p + ROUND_BIAS;
    q   = $signed(s[MulW-1:Shift]);
    ovf = (q[QW-1:EntryW-1] != {(QW-EntryW+1){q[EntryW-1]}});
    if (ovf) begin
      round_sat = q[QW-1] ? {1'b1, {(EntryW-1){1'b0}}} : {1'b0, {(EntryW-1){1'b1}}};
    end else begin
      round_sat = $signed(q[EntryW-1:0]);
    end
  endfunction

endpackage

// ----- hw/rtl/trs_if.sv -----
// Valid/ready channel interfaces for the input and result words.
interface trs_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [trs_pkg::PosW-1:0]    pos_x;
  logic signed [trs_pkg::PosW-1:0]    pos_y;
  logic signed [trs_pkg::PosW-1:0]    pos_z;
  logic signed [trs_pkg::QuatW-1:0]   quat_w;
  logic signed [trs_pkg::QuatW-1:0]   quat_x;
  logic signed [trs_pkg::QuatW-1:0]   quat_y;
  logic signed [trs_pkg::QuatW-1:0]   quat_z;
  logic signed [trs_pkg::ScaleW-1:0]  scale_x;
  logic signed [trs_pkg::ScaleW-1:0]  scale_y;
  logic signed [trs_pkg::ScaleW-1:0]  scale_z;

  modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                  scale_x, scale_y, scale_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                scale_x, scale_y, scale_z, output ready);
endinterface

interface trs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [trs_pkg::EntryW-1:0]  m00;
  logic signed [trs_pkg::EntryW-1:0]  m10;
  logic signed [trs_pkg::EntryW-1:0]  m20;
  logic signed [trs_pkg::EntryW-1:0]  m01;
  logic signed [trs_pkg::EntryW-1:0]  m11;
  logic signed [trs_pkg::EntryW-1:0]  m21;
  logic signed [trs_pkg::EntryW-1:0]  m02;
  logic signed [trs_pkg::EntryW-1:0]  m12;
  logic signed [trs_pkg::EntryW-1:0]  m22;
  logic signed [trs_pkg::PosW-1:0]    tx;
  logic signed [trs_pkg::PosW-1:0]    ty;
  logic signed [trs_pkg::PosW-1:0]    tz;

  modport source (output valid, m00, m10, m20, m01, m11, m21, m02, m12, m22, tx, ty, tz,
                  input ready);
  modport sink (input valid, m00, m10, m20, m01, m11, m21, m02, m12, m22, tx, ty, tz,
                output ready);
endinterface

// ----- hw/rtl/trs_prod.sv -----
// Stage 1: the nine quaternion component products.
module trs_prod (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  trs_pkg::quat_t in_quat,
  input  trs_pkg::side_t in_side,
  output logic           out_valid,
  input  logic           out_ready,
  output trs_pkg::prod_t out_prod,
  output trs_pkg::side_t out_side
);

  logic           valid_r;
  trs_pkg::prod_t prod_r;
  trs_pkg::prod_t prod_nxt;
  trs_pkg::side_t side_r;
  logic           load;

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    prod_nxt.xx = trs_pkg::ProdW'(in_quat.x) * trs_pkg::ProdW'(in_quat.x);
    prod_nxt.yy = trs_pkg::ProdW'(in_quat.y) * trs_pkg::ProdW'(in_quat.y);
    prod_nxt.zz = trs_pkg::ProdW'(in_quat.z) * trs_pkg::ProdW'(in_quat.z);
    prod_nxt.xy = trs_pkg::ProdW'(in_quat.x) * trs_pkg::ProdW'(in_quat.y);
    prod_nxt.xz = trs_pkg::ProdW'(in_quat.x) * trs_pkg::ProdW'(in_quat.z);
    prod_nxt.yz = trs_pkg::ProdW'(in_quat.y) * trs_pkg::ProdW'(in_quat.z);
    prod_nxt.wx = trs_pkg::ProdW'(in_quat.w) * trs_pkg::ProdW'(in_quat.x);
    prod_nxt.wy = trs_pkg::ProdW'(in_quat.w) * trs_pkg::ProdW'(in_quat.y);
    prod_nxt.wz = trs_pkg::ProdW'(in_quat.w) * trs_pkg::ProdW'(in_quat.z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_prod  = prod_r;
  assign out_side  = side_r;

endmodule

// ----- hw/rtl/trs_rot.sv -----
// Stage 2: sums the products into the nine rotation entries (Q.28).
module trs_rot (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  trs_pkg::prod_t                    in_prod,
  input  trs_pkg::side_t                    in_side,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [trs_pkg::RotW-1:0]   out_rot [trs_pkg::NumEnt],
  output trs_pkg::side_t                    out_side
);

  logic                             valid_r;
  logic signed [trs_pkg::RotW-1:0]  rot_r   [trs_pkg::NumEnt];
  logic signed [trs_pkg::RotW-1:0]  rot_nxt [trs_pkg::NumEnt];
  trs_pkg::side_t                   side_r;
  logic signed [trs_pkg::RotW-1:0]  xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic                             load;

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    xx = trs_pkg::RotW'(in_prod.xx);
    yy = trs_pkg::RotW'(in_prod.yy);
    zz = trs_pkg::RotW'(in_prod.zz);
    xy = trs_pkg::RotW'(in_prod.xy);
    xz = trs_pkg::RotW'(in_prod.xz);
    yz = trs_pkg::RotW'(in_prod.yz);
    wx = trs_pkg::RotW'(in_prod.wx);
    wy = trs_pkg::RotW'(in_prod.wy);
    wz = trs_pkg::RotW'(in_prod.wz);
    // column-major: m00 m10 m20 m01 m11 m21 m02 m12 m22
    rot_nxt[0] = trs_pkg::ONE_Q28 - ((yy + zz) <<< 1);
    rot_nxt[1] = (xy + wz) <<< 1;
    rot_nxt[2] = (xz - wy) <<< 1;
    rot_nxt[3] = (xy - wz) <<< 1;
    rot_nxt[4] = trs_pkg::ONE_Q28 - ((xx + zz) <<< 1);
    rot_nxt[5] = (yz + wx) <<< 1;
    rot_nxt[6] = (xz + wy) <<< 1;
    rot_nxt[7] = (yz - wx) <<< 1;
    rot_nxt[8] = trs_pkg::ONE_Q28 - ((xx + yy) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rot_r  <= rot_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rot   = rot_r;
  assign out_side  = side_r;

endmodule

// ----- hw/rtl/trs_scl.sv -----
// Stages 3 and 4: column scale multiply, then round and saturate to Q9.14.
module trs_scl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [trs_pkg::RotW-1:0]   in_rot [trs_pkg::NumEnt],
  input  trs_pkg::side_t                    in_side,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [trs_pkg::EntryW-1:0] out_ent [trs_pkg::NumEnt],
  output trs_pkg::pos_t                     out_pos
);

  logic                               mul_valid_r;
  logic                               mul_ready;
  logic signed [trs_pkg::MulW-1:0]    mul_r   [trs_pkg::NumEnt];
  logic signed [trs_pkg::MulW-1:0]    mul_nxt [trs_pkg::NumEnt];
  trs_pkg::pos_t                      mul_pos_r;
  logic signed [trs_pkg::ScaleW-1:0]  col_scale [3];

  logic                               ent_valid_r;
  logic signed [trs_pkg::EntryW-1:0]  ent_r   [trs_pkg::NumEnt];
  logic signed [trs_pkg::EntryW-1:0]  ent_nxt [trs_pkg::NumEnt];
  trs_pkg::pos_t                      ent_pos_r;

  assign col_scale[0] = in_side.scale.x;
  assign col_scale[1] = in_side.scale.y;
  assign col_scale[2] = in_side.scale.z;

  assign in_ready  = !mul_valid_r || mul_ready;
  assign mul_ready = !ent_valid_r || out_ready;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        mul_nxt[j*3+i] = trs_pkg::MulW'(in_rot[j*3+i]) * trs_pkg::MulW'(col_scale[j]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < trs_pkg::NumEnt; k++) begin
      ent_nxt[k] = trs_pkg::round_sat(mul_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      ent_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        mul_valid_r <= in_valid;
      end
      if (mul_ready) begin
        ent_valid_r <= mul_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mul_r     <= mul_nxt;
      mul_pos_r <= in_side.pos;
    end
    if (mul_valid_r && mul_ready) begin
      ent_r     <= ent_nxt;
      ent_pos_r <= mul_pos_r;
    end
  end

  assign out_valid = ent_valid_r;
  assign out_ent   = ent_r;
  assign out_pos   = ent_pos_r;

endmodule

// ----- hw/rtl/trs_model_matrix_core.sv -----
// Top level of the TRS model matrix pipeline: position, quaternion, scale in; T*R*S out.
//
//   channel  dir  contents
//   in_ch    in   pos_x/y/z Q16.16, quat_w/x/y/z Q1.14, scale_x/y/z Q8.8
//   out_ch   out  m00..m22 Q9.14 saturated, tx/ty/tz Q16.16
//
// One word per cycle while out_ch.ready holds; four register stages (products,
// rotation sums, scale multiply, round/saturate) hold the words in flight.
// Each stage holds one word with its own valid bit; ready ripples back so a
// stalled output keeps the upstream stages filling bubbles, nothing dropped.
// Synchronous active-low reset clears the valid bits only.
module trs_model_matrix_core (
  input  logic       clk,
  input  logic       rst_n,
  trs_in_if.sink     in_ch,
  trs_out_if.source  out_ch
);

  trs_pkg::quat_t                     quat;
  trs_pkg::side_t                     side;

  logic                               prod_valid;
  logic                               prod_ready;
  trs_pkg::prod_t                     prod;
  trs_pkg::side_t                     prod_side;

  logic                               rot_valid;
  logic                               rot_ready;
  logic signed [trs_pkg::RotW-1:0]    rot [trs_pkg::NumEnt];
  trs_pkg::side_t                     rot_side;

  logic signed [trs_pkg::EntryW-1:0]  ent [trs_pkg::NumEnt];
  trs_pkg::pos_t                      pos;

  assign quat.w        = in_ch.quat_w;
  assign quat.x        = in_ch.quat_x;
  assign quat.y        = in_ch.quat_y;
  assign quat.z        = in_ch.quat_z;
  assign side.pos.x    = in_ch.pos_x;
  assign side.pos.y    = in_ch.pos_y;
  assign side.pos.z    = in_ch.pos_z;
  assign side.scale.x  = in_ch.scale_x;
  assign side.scale.y  = in_ch.scale_y;
  assign side.scale.z  = in_ch.scale_z;

  trs_prod u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_quat   (quat),
    .in_side   (side),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_prod  (prod),
    .out_side  (prod_side)
  );

  trs_rot u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_prod   (prod),
    .in_side   (prod_side),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_rot   (rot),
    .out_side  (rot_side)
  );

  trs_scl u_scl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_rot    (rot),
    .in_side   (rot_side),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_ent   (ent),
    .out_pos   (pos)
  );

  assign out_ch.m00 = ent[0];
  assign out_ch.m10 = ent[1];
  assign out_ch.m20 = ent[2];
  assign out_ch.m01 = ent[3];
  assign out_ch.m11 = ent[4];
  assign out_ch.m21 = ent[5];
  assign out_ch.m02 = ent[6];
  assign out_ch.m12 = ent[7];
  assign out_ch.m22 = ent[8];
  assign out_ch.tx  = pos.x;
  assign out_ch.ty  = pos.y;
  assign out_ch.tz  = pos.z;

endmodule
